// ----- rtl/tcce_pkg.sv -----
package tcce_pkg;

  // character codes with special handling
  localparam logic [7:0] CH_NEWLINE   = 8'h0A;
  localparam logic [7:0] CH_BACKSPACE = 8'h08;
  localparam logic [7:0] CH_BLANK     = 8'h20;

  // configuration register indexes
  localparam logic [2:0] REG_ENABLE   = 3'd0;
  localparam logic [2:0] REG_COLUMNS  = 3'd1;
  localparam logic [2:0] REG_ROWS     = 3'd2;
  localparam logic [2:0] REG_FG_INDEX = 3'd3;
  localparam logic [2:0] REG_BG_INDEX = 3'd4;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 9;

  // reset values of the configuration registers
  localparam logic       RST_ENABLE   = 1'b0;
  localparam logic [8:0] RST_COLUMNS  = 9'd80;
  localparam logic [7:0] RST_ROWS     = 8'd25;
  localparam logic [3:0] RST_FG_INDEX = 4'hF;
  localparam logic [3:0] RST_BG_INDEX = 4'h0;

  // cursor field widths
  localparam int unsigned COL_W = 8;
  localparam int unsigned ROW_W = 7;
  localparam int unsigned RGB_W = 24;

  // padded output word: 86 field bits rounded up to whole bytes
  localparam int unsigned OUT_DATA_W = 88;

  typedef enum logic {
    ACT_DRAW   = 1'b0,
    ACT_SCROLL = 1'b1
  } action_e;

  typedef struct packed {
    logic       enable;
    logic [8:0] columns;
    logic [7:0] rows;
    logic [3:0] fg_index;
    logic [3:0] bg_index;
  } cfg_t;

  // decoded command handed from front to back
  typedef struct packed {
    logic             has_draw;
    logic             has_scroll;
    logic [COL_W-1:0] draw_col;
    logic [ROW_W-1:0] draw_row;
    logic [7:0]       glyph;
    logic [3:0]       fg_index;
    logic [3:0]       bg_index;
    logic [COL_W-1:0] col_after;
    logic [ROW_W-1:0] row_after;
  } cmd_t;

  // fixed 16-color text-mode palette
  function automatic logic [RGB_W-1:0] palette_rgb(input logic [3:0] idx);
    logic [RGB_W-1:0] rgb;
    case (idx)
      4'd0:    rgb = 24'h000000;
      4'd1:    rgb = 24'h0000AA;
      4'd2:    rgb = 24'h00AA00;
      4'd3:    rgb = 24'h00AAAA;
      4'd4:    rgb = 24'hAA0000;
      4'd5:    rgb = 24'hAA00AA;
      4'd6:    rgb = 24'hAA5500;
      4'd7:    rgb = 24'hAAAAAA;
      4'd8:    rgb = 24'h555555;
      4'd9:    rgb = 24'h5555FF;
      4'd10:   rgb = 24'h55FF55;
      4'd11:   rgb = 24'h55FFFF;
      4'd12:   rgb = 24'hFF5555;
      4'd13:   rgb = 24'hFF55FF;
      4'd14:   rgb = 24'hFFFF55;
      default: rgb = 24'hFFFFFF;
    endcase
    return rgb;
  endfunction

endpackage

// ----- rtl/tcce_front.sv -----
module tcce_front import tcce_pkg::*; #(
  parameter int unsigned MAX_COLS = 256,
  parameter int unsigned MAX_ROWS = 128
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] char_i,
  output logic       push_valid_o,
  input  logic       push_ready_i,
  output cmd_t       push_cmd_o
);

  // grid limits: what the parameters allow, capped by the cursor widths
  localparam int unsigned ColCap = (MAX_COLS < 256) ? MAX_COLS : 256;
  localparam int unsigned RowCap = (MAX_ROWS < 128) ? MAX_ROWS : 128;
  localparam logic [8:0]  COL_LIM = 9'((ColCap < 1) ? 1 : ColCap);
  localparam logic [7:0]  ROW_LIM = 8'((RowCap < 1) ? 1 : RowCap);

  logic [COL_W-1:0] col_q, col_d;
  logic [ROW_W-1:0] row_q, row_d;

  logic [8:0]       ncols;
  logic [7:0]       nrows;
  logic [COL_W-1:0] last_col, col_c;
  logic [ROW_W-1:0] last_row, row_c;
  logic [8:0]       col_inc;
  logic [7:0]       row_inc;
  logic             wrap_scroll;
  logic             accept;
  cmd_t             cmd;

  assign in_ready_o = push_ready_i;
  assign accept     = in_valid_i && push_ready_i && cfg_i.enable;

  always_comb begin
    ncols = cfg_i.columns;
    if (ncols == 9'd0) ncols = 9'd1;
    if (ncols > COL_LIM) ncols = COL_LIM;
    nrows = cfg_i.rows;
    if (nrows == 8'd0) nrows = 8'd1;
    if (nrows > ROW_LIM) nrows = ROW_LIM;
  end

  assign last_col    = COL_W'(ncols - 9'd1);
  assign last_row    = ROW_W'(nrows - 8'd1);
  // a shrunken grid pulls the cursor back inside first
  assign col_c       = ({1'b0, col_q} >= ncols) ? last_col : col_q;
  assign row_c       = ({1'b0, row_q} >= nrows) ? last_row : row_q;
  assign col_inc     = {1'b0, col_c} + 9'd1;
  assign row_inc     = {1'b0, row_c} + 8'd1;
  assign wrap_scroll = (row_inc >= nrows);

  always_comb begin
    cmd          = '0;
    cmd.fg_index = cfg_i.fg_index;
    cmd.bg_index = cfg_i.bg_index;
    col_d        = col_c;
    row_d        = row_c;
    unique case (char_i)
      CH_NEWLINE: begin
        col_d          = '0;
        cmd.has_scroll = wrap_scroll;
        row_d          = wrap_scroll ? last_row : row_inc[ROW_W-1:0];
      end
      CH_BACKSPACE: begin
        if (col_c != '0) begin
          col_d = col_c - COL_W'(1);
        end else if (row_c != '0) begin
          row_d = row_c - ROW_W'(1);
          col_d = last_col;
        end
        cmd.has_draw = 1'b1;
        cmd.draw_col = col_d;
        cmd.draw_row = row_d;
        cmd.glyph    = CH_BLANK;
      end
      default: begin
        cmd.has_draw = 1'b1;
        cmd.draw_col = col_c;
        cmd.draw_row = row_c;
        cmd.glyph    = char_i;
        if (col_inc >= ncols) begin
          col_d          = '0;
          cmd.has_scroll = wrap_scroll;
          row_d          = wrap_scroll ? last_row : row_inc[ROW_W-1:0];
        end else begin
          col_d = col_inc[COL_W-1:0];
        end
      end
    endcase
    cmd.col_after = col_d;
    cmd.row_after = row_d;
  end

  // plain newline moves the cursor only; nothing goes to the back end
  assign push_valid_o = accept && (cmd.has_draw || cmd.has_scroll);
  assign push_cmd_o   = cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (accept) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

endmodule

// ----- rtl/tcce_queue.sv -----
module tcce_queue import tcce_pkg::*; #(
  parameter int unsigned DEPTH = 4
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_valid_i,
  output logic push_ready_o,
  input  cmd_t push_cmd_i,
  output logic pop_valid_o,
  input  logic pop_ready_i,
  output cmd_t pop_cmd_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  cmd_t          mem_q [DEPTH];
  logic [AW-1:0] wr_ptr_q, wr_ptr_d;
  logic [AW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] count_q, count_d;
  logic          push, pop;

  assign push_ready_o = (count_q != CW'(DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_cmd_o    = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
    end
    if (push && !pop) begin
      count_d = count_q + CW'(1);
    end else if (pop && !push) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

// ----- rtl/tcce_back.sv -----
module tcce_back import tcce_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  pop_valid_i,
  output logic                  pop_ready_o,
  input  cmd_t                  pop_cmd_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [OUT_DATA_W-1:0] out_data_o,
  output logic                  out_user_o,
  output logic                  out_last_o
);

  logic                  out_valid_q, out_valid_d;
  logic [OUT_DATA_W-1:0] out_data_q, out_data_d;
  logic                  out_user_q, out_user_d;
  logic                  out_last_q, out_last_d;
  logic                  phase_q, phase_d;   // draw word of a two-word command sent
  logic                  load, emit;

  logic             act;
  logic [COL_W-1:0] cell_col;
  logic [ROW_W-1:0] cell_row;
  logic [7:0]       glyph;
  logic [RGB_W-1:0] fg_rgb, bg_rgb;

  assign load   = !out_valid_q || out_ready_i;
  assign bg_rgb = palette_rgb(pop_cmd_i.bg_index);

  always_comb begin
    pop_ready_o = 1'b0;
    emit        = 1'b0;
    phase_d     = phase_q;
    act         = ACT_DRAW;
    cell_col    = '0;
    cell_row    = '0;
    glyph       = '0;
    fg_rgb      = '0;
    out_last_d  = 1'b1;
    if (load && pop_valid_i) begin
      emit = 1'b1;
      if (pop_cmd_i.has_draw && !phase_q) begin
        cell_col   = pop_cmd_i.draw_col;
        cell_row   = pop_cmd_i.draw_row;
        glyph      = pop_cmd_i.glyph;
        fg_rgb     = palette_rgb(pop_cmd_i.fg_index);
        out_last_d = !pop_cmd_i.has_scroll;
        if (pop_cmd_i.has_scroll) begin
          phase_d = 1'b1;
        end else begin
          pop_ready_o = 1'b1;
        end
      end else begin
        act         = ACT_SCROLL;
        pop_ready_o = 1'b1;
        phase_d     = 1'b0;
      end
    end
    out_valid_d = load ? emit : out_valid_q;
    out_user_d  = act;
    out_data_d  = {2'b00, pop_cmd_i.row_after, pop_cmd_i.col_after,
                   bg_rgb, fg_rgb, glyph, cell_row, cell_col};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      phase_q     <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      phase_q     <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_data_q <= out_data_d;
      out_user_q <= out_user_d;
      out_last_q <= out_last_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign out_user_o  = out_user_q;
  assign out_last_o  = out_last_q;

endmodule

// ----- rtl/text_console_cursor_engine.sv -----
// A character's command is registered in the queue, then in the output register.
// Throughput: one character per cycle unless the queue is full; one that draws and
//   scrolls emits a draw, then a scroll word, through the single output register.
// A 4-entry command queue lets the input side run ahead of a stalled output.
// Reset: cursor at (0,0), registers at defaults (disabled, 80x25, white on black),
//   queue and output register empty.
module text_console_cursor_engine import tcce_pkg::*; #(
  parameter int unsigned MAX_COLS = 256,
  parameter int unsigned MAX_ROWS = 128
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration write channel
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  // character stream in
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [7:0]            s_axis_tdata,   // [7:0] char_code
  // result stream out
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [7:0] cell_col, [14:8] cell_row, [22:15] glyph_code, [46:23] fg_rgb,
  // [70:47] bg_rgb, [78:71] cursor_col_after, [85:79] cursor_row_after, [87:86] zero
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  output logic [0:0]            m_axis_tuser,   // [0] action (0 draw, 1 scroll)
  output logic                  m_axis_tlast    // last word of this character
);

  localparam int unsigned QueueDepth = 4;

  cfg_t cfg_q, cfg_d;
  logic push_valid, push_ready, pop_valid, pop_ready;
  cmd_t push_cmd, pop_cmd;
  logic out_user;

  // register file; the user makes writes only while the engine is idle; the block does not enforce it
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_ENABLE:   cfg_d.enable   = cfg_data_i[0];
        REG_COLUMNS:  cfg_d.columns  = cfg_data_i[8:0];
        REG_ROWS:     cfg_d.rows     = cfg_data_i[7:0];
        REG_FG_INDEX: cfg_d.fg_index = cfg_data_i[3:0];
        REG_BG_INDEX: cfg_d.bg_index = cfg_data_i[3:0];
        default:      cfg_d          = cfg_q;   // unmapped index, dropped
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.enable   <= RST_ENABLE;
      cfg_q.columns  <= RST_COLUMNS;
      cfg_q.rows     <= RST_ROWS;
      cfg_q.fg_index <= RST_FG_INDEX;
      cfg_q.bg_index <= RST_BG_INDEX;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // front: cursor tracking and command decode, one character per cycle while the queue has room
  tcce_front #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .char_i       (s_axis_tdata),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_cmd_o   (push_cmd)
  );

  tcce_queue #(
    .DEPTH (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_cmd_i   (push_cmd),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_cmd_o    (pop_cmd)
  );

  // back: expands each command into draw and scroll words, palette lookup
  tcce_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_cmd_i   (pop_cmd),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_user_o  (out_user),
    .out_last_o  (m_axis_tlast)
  );

  assign m_axis_tuser[0] = out_user;

endmodule

// ----- tb/sv/tcce_console_checker.sv -----
`timescale 1ns / 100ps

// Watches the config, character and result channels, keeps its own cursor and
// register copy, and compares every result word with the oldest prediction.
module tcce_console_checker import tcce_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  input  logic                  cfg_ready_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  s_tvalid_i,
  input  logic                  s_tready_i,
  input  logic [7:0]            s_tdata_i,
  input  logic                  m_tvalid_i,
  input  logic                  m_tready_i,
  input  logic [OUT_DATA_W-1:0] m_tdata_i,
  input  logic [0:0]            m_tuser_i,
  input  logic                  m_tlast_i,
  output int                    errors_o,
  output int                    pending_o
);

  typedef struct packed {
    action_e          act;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic [7:0]       glyph;
    logic [RGB_W-1:0] fg;
    logic [RGB_W-1:0] bg;
    logic [COL_W-1:0] col_after;
    logic [ROW_W-1:0] row_after;
    logic             last;
  } console_op_t;

  cfg_t             shadow_cfg;
  logic [COL_W-1:0] cur_col;
  logic [ROW_W-1:0] cur_row;
  console_op_t      ops_due[$];
  int               mismatch_cnt = 0;

  assign errors_o = mismatch_cnt;

  function automatic logic [RGB_W-1:0] vga_color(input logic [3:0] idx);
    case (idx)
      4'h0:    return 24'h000000;
      4'h1:    return 24'h0000AA;
      4'h2:    return 24'h00AA00;
      4'h3:    return 24'h00AAAA;
      4'h4:    return 24'hAA0000;
      4'h5:    return 24'hAA00AA;
      4'h6:    return 24'hAA5500;
      4'h7:    return 24'hAAAAAA;
      4'h8:    return 24'h555555;
      4'h9:    return 24'h5555FF;
      4'hA:    return 24'h55FF55;
      4'hB:    return 24'h55FFFF;
      4'hC:    return 24'hFF5555;
      4'hD:    return 24'hFF55FF;
      4'hE:    return 24'hFFFF55;
      default: return 24'hFFFFFF;
    endcase
  endfunction

  // Moves the cursor for one character and queues the words it produces.
  function automatic void track_char(input logic [7:0] c);
    int               ncols;
    int               nrows;
    int               col;
    int               row;
    logic             scroll;
    logic [RGB_W-1:0] fg;
    logic [RGB_W-1:0] bg;
    console_op_t      op;
    console_op_t      fresh[$];
    if (!shadow_cfg.enable) return;
    ncols = (shadow_cfg.columns == '0) ? 1 : int'(shadow_cfg.columns);
    if (ncols > 256) ncols = 256;
    nrows = (shadow_cfg.rows == '0) ? 1 : int'(shadow_cfg.rows);
    if (nrows > 128) nrows = 128;
    fg = vga_color(shadow_cfg.fg_index);
    bg = vga_color(shadow_cfg.bg_index);
    col = int'(cur_col);
    row = int'(cur_row);
    // grid may have shrunk under the cursor
    if (col >= ncols) col = ncols - 1;
    if (row >= nrows) row = nrows - 1;
    scroll = 1'b0;
    op = '0;
    if (c == CH_NEWLINE) begin
      col = 0;
      row++;
      scroll = (row >= nrows);
    end else if (c == CH_BACKSPACE) begin
      if (col > 0) begin
        col--;
      end else if (row > 0) begin
        row--;
        col = ncols - 1;
      end
      op.act   = ACT_DRAW;
      op.col   = COL_W'(col);
      op.row   = ROW_W'(row);
      op.glyph = CH_BLANK;
      op.fg    = fg;
      op.bg    = bg;
      fresh.push_back(op);
    end else begin
      op.act   = ACT_DRAW;
      op.col   = COL_W'(col);
      op.row   = ROW_W'(row);
      op.glyph = c;
      op.fg    = fg;
      op.bg    = bg;
      fresh.push_back(op);
      col++;
      if (col >= ncols) begin
        col = 0;
        row++;
        scroll = (row >= nrows);
      end
    end
    if (scroll) begin
      row = nrows - 1;
      op     = '0;
      op.act = ACT_SCROLL;
      op.bg  = bg;
      fresh.push_back(op);
    end
    foreach (fresh[k]) begin
      op           = fresh[k];
      op.col_after = COL_W'(col);
      op.row_after = ROW_W'(row);
      op.last      = (k == fresh.size() - 1);
      ops_due.push_back(op);
    end
    cur_col = COL_W'(col);
    cur_row = ROW_W'(row);
  endfunction

  function automatic void check_field(input string name, input logic [RGB_W-1:0] want,
                                      input logic [RGB_W-1:0] got);
    if (got !== want) begin
      mismatch_cnt++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    console_op_t head;
    if (!rst_ni) begin
      shadow_cfg = '{RST_ENABLE, RST_COLUMNS, RST_ROWS, RST_FG_INDEX, RST_BG_INDEX};
      cur_col    = '0;
      cur_row    = '0;
      ops_due.delete();
      pending_o <= 0;
    end else begin
      // result side first: a word at this edge belongs to an older character
      if (m_tvalid_i && m_tready_i) begin
        if (ops_due.size() == 0) begin
          mismatch_cnt++;
          $display("%0t: result word with none expected, expected none, got %h/%b/%b",
                   $time, m_tdata_i, m_tuser_i, m_tlast_i);
        end else begin
          head = ops_due.pop_front();
          check_field("action", head.act, m_tuser_i[0]);
          check_field("cell_col", head.col, m_tdata_i[7:0]);
          check_field("cell_row", head.row, m_tdata_i[14:8]);
          check_field("glyph_code", head.glyph, m_tdata_i[22:15]);
          check_field("fg_rgb", head.fg, m_tdata_i[46:23]);
          check_field("bg_rgb", head.bg, m_tdata_i[70:47]);
          check_field("cursor_col_after", head.col_after, m_tdata_i[78:71]);
          check_field("cursor_row_after", head.row_after, m_tdata_i[85:79]);
          check_field("tdata pad", '0, m_tdata_i[87:86]);
          check_field("last", head.last, m_tlast_i);
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_ENABLE:   shadow_cfg.enable   = cfg_data_i[0];
          REG_COLUMNS:  shadow_cfg.columns  = cfg_data_i[8:0];
          REG_ROWS:     shadow_cfg.rows     = cfg_data_i[7:0];
          REG_FG_INDEX: shadow_cfg.fg_index = cfg_data_i[3:0];
          REG_BG_INDEX: shadow_cfg.bg_index = cfg_data_i[3:0];
          default: ;
        endcase
      end
      if (s_tvalid_i && s_tready_i) track_char(s_tdata_i);
      pending_o <= ops_due.size();
    end
  end

endmodule

// ----- tb/sv/tb_text_console_cursor_engine.sv -----
`timescale 1ns / 100ps

// Stimulus and verdict for the console cursor engine. The checker beside the
// block does all prediction; this module only feeds words and decides.
module tb_text_console_cursor_engine;
  import tcce_pkg::*;

  localparam int CLK_HALF      = 6;        // 12 ns period
  localparam int LIMIT_CYCLES  = 200000;   // far above the slowest legal run
  localparam int SETTLE_CYCLES = 8;        // covers a newline still in the queue
  localparam int HOLD_CYCLES   = 250;      // long result-side stall
  localparam int HOLD_EVERY    = 450;      // words between long stalls

  typedef enum logic [1:0] {
    RX_FULL,    // always ready
    RX_COIN,    // ready half the time
    RX_SPARSE,  // ready a quarter of the time
    RX_BEAT     // fixed rhythm, ready two thirds of the time
  } rx_mode_e;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  // config channel
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  // character stream
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata  = '0;    // [7:0] char_code

  // result stream
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  // [7:0] cell_col, [14:8] cell_row, [22:15] glyph_code, [46:23] fg_rgb,
  // [70:47] bg_rgb, [78:71] cursor_col_after, [85:79] cursor_row_after
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [0:0]            m_tuser;  // [0] action
  logic                  m_tlast;

  int errors;
  int pending;
  int cycle_cnt  = 0;
  int burst_left = 0;

  // receiver state, owned by the receiver process
  rx_mode_e rx_mode   = RX_FULL;
  int       mode_left = 0;
  int       hold_left = 0;
  int       words_in  = 0;
  int       next_hold = 150;

  always #(CLK_HALF) clk = ~clk;

  text_console_cursor_engine i_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata),
    .m_axis_tuser  (m_tuser),
    .m_axis_tlast  (m_tlast)
  );

  tcce_console_checker i_console_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_i (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .s_tvalid_i  (s_tvalid),
    .s_tready_i  (s_tready),
    .s_tdata_i   (s_tdata),
    .m_tvalid_i  (m_tvalid),
    .m_tready_i  (m_tready),
    .m_tdata_i   (m_tdata),
    .m_tuser_i   (m_tuser),
    .m_tlast_i   (m_tlast),
    .errors_o    (errors),
    .pending_o   (pending)
  );

  // Watchdog: a stuck handshake or a lost word ends the run here.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= LIMIT_CYCLES) begin
      $display("%0t: timed out, %0d result words still expected", $time, pending);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Receiver. Switches between stall patterns at random, and every HOLD_EVERY
  // accepted characters holds off for a long stretch so the command queue fills
  // and the block has to drop s_tready.
  always @(posedge clk) begin
    if (s_tvalid && s_tready) words_in++;
    if (hold_left == 0 && words_in >= next_hold) begin
      hold_left = HOLD_CYCLES;
      next_hold += HOLD_EVERY;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        rx_mode   = rx_mode_e'($urandom_range(0, 3));
        mode_left = $urandom_range(10, 80);
      end
      mode_left--;
      case (rx_mode)
        RX_FULL:   m_tready <= 1'b1;
        RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
        RX_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
        default:   m_tready <= ((mode_left % 3) != 0);
      endcase
    end
  end

  // Drop the stream, wait until the checker has nothing outstanding, then
  // give a newline still inside the block time to retire.
  task automatic settle();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write the enable register alone, or all five registers, on an idle block.
  // Valid stays high across back-to-back writes and drops once at the end.
  task automatic load_regs(input bit all_regs, input logic [CFG_DATA_W-1:0] en,
                           input logic [CFG_DATA_W-1:0] cols,
                           input logic [CFG_DATA_W-1:0] rows,
                           input logic [CFG_DATA_W-1:0] fg,
                           input logic [CFG_DATA_W-1:0] bg);
    logic [CFG_IDX_W-1:0]  reg_ids [5];
    logic [CFG_DATA_W-1:0] vals [5];
    int                    top_reg;
    reg_ids = '{REG_ENABLE, REG_COLUMNS, REG_ROWS, REG_FG_INDEX, REG_BG_INDEX};
    vals    = '{en, cols, rows, fg, bg};
    top_reg = all_regs ? 4 : 0;
    settle();
    for (int i = 0; i <= top_reg; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= reg_ids[i];
      cfg_data  <= vals[i];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
  endtask

  // One character word. Bursts of random length, separated by random gaps;
  // a zero gap runs two bursts together.
  task automatic send_char(input logic [7:0] c);
    int gap;
    s_tvalid <= 1'b1;
    s_tdata  <= c;
    do @(posedge clk); while (!s_tready);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      gap        = $urandom_range(0, 5);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Random characters with chosen newline and backspace shares (percent);
  // the rest are any byte, so control codes also turn up by chance.
  task automatic stream_chars(input int count, input int nl_pct, input int bs_pct);
    int roll;
    for (int i = 0; i < count; i++) begin
      roll = $urandom_range(0, 99);
      if (roll < nl_pct)               send_char(CH_NEWLINE);
      else if (roll < nl_pct + bs_pct) send_char(CH_BACKSPACE);
      else                             send_char(8'($urandom_range(0, 255)));
    end
  endtask

  // Mostly small grids so wraps and scrolls come often; sometimes anything
  // the register holds, zero and oversize included.
  function automatic logic [CFG_DATA_W-1:0] grid_size(input int reg_max, input int usual_max);
    if ($urandom_range(0, 3) == 0) return CFG_DATA_W'($urandom_range(0, reg_max));
    return CFG_DATA_W'($urandom_range(1, usual_max));
  endfunction

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // --- directed part ---
    // out of reset the console is off: both words vanish
    send_char(8'h41);
    send_char(CH_NEWLINE);

    // enable only, so the 80x25 white-on-black reset grid is exercised
    load_regs(1'b0, 9'd1, '0, '0, '0, '0);
    send_char(CH_BACKSPACE);   // at origin: stays, blank drawn at (0,0)
    send_char(8'h00);
    send_char(8'hFF);
    send_char(CH_NEWLINE);     // plain newline, no word out
    send_char(CH_BACKSPACE);   // wraps back to the end of row 0

    // shrink to 1x1 under a cursor at column 79: clamp before handling
    load_regs(1'b1, 9'd1, 9'd1, 9'd1, 9'd0, 9'd15);
    send_char(8'h7F);          // draw then scroll
    send_char(CH_NEWLINE);     // scroll only
    send_char(CH_BACKSPACE);
    send_char(8'h55);

    // oversize registers act as the widest grid
    load_regs(1'b1, 9'd1, 9'd511, 9'd255, 9'd9, 9'd6);
    send_char(CH_NEWLINE);
    send_char(8'hAA);

    // zero-sized registers act as one cell
    load_regs(1'b1, 9'd1, 9'd0, 9'd0, 9'd10, 9'd15);
    send_char(8'h30);
    send_char(CH_NEWLINE);

    // console off again
    load_regs(1'b0, 9'd0, '0, '0, '0, '0);
    send_char(8'h31);
    send_char(CH_BACKSPACE);

    // --- random part ---
    // widest row: the cursor runs through every column and wraps
    load_regs(1'b1, 9'd1, 9'd256, 9'd2, 9'($urandom_range(0, 15)),
              9'($urandom_range(0, 15)));
    stream_chars(280, 1, 3);

    // tallest screen, two columns: rows climb to the bottom and scroll
    load_regs(1'b1, 9'd1, 9'd2, 9'd128, 9'($urandom_range(0, 15)),
              9'($urandom_range(0, 15)));
    stream_chars(320, 5, 5);

    // assorted small and odd grids; a shrink can clamp a far-out cursor
    for (int p = 0; p < 6; p++) begin
      load_regs(1'b1, 9'($urandom_range(0, 5) != 0), grid_size(511, 6), grid_size(255, 5),
                9'($urandom_range(0, 15)), 9'($urandom_range(0, 15)));
      stream_chars(35, 15, 15);
    end

    settle();
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/tcce_pkg.sv
rtl/tcce_front.sv
rtl/tcce_queue.sv
rtl/tcce_back.sv
rtl/text_console_cursor_engine.sv
tb/sv/tcce_console_checker.sv
tb/sv/tb_text_console_cursor_engine.sv
